### hdl/operand_stack_one_two_slot_unit_macros.svh
// assertion macros for the operand stack unit
`ifndef OPERAND_STACK_ONE_TWO_SLOT_UNIT_MACROS_SVH
`define OPERAND_STACK_ONE_TWO_SLOT_UNIT_MACROS_SVH

// same-cycle implication
`define OSTACK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OSTACK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ostack_pkg.sv
// types and constants shared by the operand stack unit
`default_nettype none

package ostack_pkg;

   localparam int WORD_W  = 32;
   localparam int DATA_W  = 64;
   localparam int DEPTH_W = 9;

   typedef enum logic [1:0] {
      OP_PUSH1 = 2'd0,
      OP_PUSH2 = 2'd1,
      OP_POP1  = 2'd2,
      OP_POP2  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } err_type;

endpackage

`default_nettype wire

### hdl/operand_stack_one_two_slot_unit.sv
// operand stack of 32-bit slots with one- and two-slot push and pop
// rsp_strobe rises in the cycle after a word is accepted; throughput: one word per cycle
// slots are split over an even and an odd ram bank, so a two-slot access
// touches each bank once and every op finishes in a single pass
// reset (synchronous) empties the stack and drops any pending response;
// busy is high only during reset, and the receiver cannot stall
`default_nettype none

module operand_stack_one_two_slot_unit
   import ostack_pkg::*;
#(
   parameter int STACK_DEPTH = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [1:0]         req_op,
   input  wire logic [DATA_W-1:0]  req_push_data,
   output      logic               rsp_strobe,
   output      logic [DATA_W-1:0]  rsp_pop_data,
   output      logic [1:0]         rsp_error_code,
   output      logic [DEPTH_W-1:0] rsp_depth,
   output      logic               rsp_is_empty
);

`include "operand_stack_one_two_slot_unit_macros.svh"

   localparam int SP_W       = $clog2(STACK_DEPTH + 1);
   localparam int BANK_DEPTH = (STACK_DEPTH + 1) / 2;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic              accept;
   op_type            op;
   logic              is_push;
   logic              is_two;
   logic [SP_W-1:0]   need;
   logic              overflow;
   logic              underflow;
   logic              push_ok;
   logic              pop_ok;
   logic [SP_W-1:0]   first_slot;
   logic [SP_W-1:0]   second_slot;
   logic [WORD_W-1:0] first_word;
   logic [WORD_W-1:0] second_word;
   logic [AW-1:0]     even_addr;
   logic [AW-1:0]     odd_addr;
   logic [WORD_W-1:0] even_wdata;
   logic [WORD_W-1:0] odd_wdata;
   logic              even_we;
   logic              odd_we;
   logic [WORD_W-1:0] even_q;
   logic [WORD_W-1:0] odd_q;
   logic [WORD_W-1:0] hi_word;
   logic [WORD_W-1:0] lo_word;

   logic [SP_W-1:0]   sp_ff,     sp_in;
   logic              strobe_ff, strobe_in;
   err_type           err_ff,    err_in;
   logic              pop_ff,    pop_in;
   logic              two_ff,    two_in;
   logic              odd_ff,    odd_in;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      op        = op_type'(req_op);
      is_push   = (op == OP_PUSH1) || (op == OP_PUSH2);
      is_two    = (op == OP_PUSH2) || (op == OP_POP2);
      need      = is_two ? SP_W'(2) : SP_W'(1);
      overflow  = is_push && (({1'b0, sp_ff} + {1'b0, need}) > (SP_W + 1)'(STACK_DEPTH));
      underflow = !is_push && (sp_ff < need);
      push_ok   = accept && is_push && !overflow;
      pop_ok    = accept && !is_push && !underflow;

      // lowest slot touched; the high word of a pair sits there
      first_slot  = is_push ? sp_ff : (sp_ff - need);
      second_slot = first_slot + SP_W'(1);
      first_word  = is_two ? req_push_data[DATA_W-1:WORD_W] : req_push_data[WORD_W-1:0];
      second_word = req_push_data[WORD_W-1:0];

      odd_addr   = AW'(first_slot >> 1);
      even_addr  = first_slot[0] ? AW'(second_slot >> 1) : AW'(first_slot >> 1);
      even_wdata = first_slot[0] ? second_word : first_word;
      odd_wdata  = first_slot[0] ? first_word : second_word;
      even_we    = push_ok && (is_two || !first_slot[0]);
      odd_we     = push_ok && (is_two || first_slot[0]);

      sp_in = sp_ff;
      if (push_ok) begin
         sp_in = sp_ff + need;
      end else if (pop_ok) begin
         sp_in = sp_ff - need;
      end

      err_in = ERR_OK;
      if (overflow) begin
         err_in = ERR_OVERFLOW;
      end else if (underflow) begin
         err_in = ERR_UNDERFLOW;
      end

      strobe_in = accept;
      pop_in    = pop_ok;
      two_in    = is_two;
      odd_in    = first_slot[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         sp_ff     <= sp_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff <= err_in;
         pop_ff <= pop_in;
         two_ff <= two_in;
         odd_ff <= odd_in;
      end
   end

   ostack_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (BANK_DEPTH),
      .ADDR_W (AW)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_addr),
      .wr_data (even_wdata),
      .rd_en   (pop_ok),
      .rd_addr (even_addr),
      .rd_data (even_q)
   );

   ostack_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (BANK_DEPTH),
      .ADDR_W (AW)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_addr),
      .wr_data (odd_wdata),
      .rd_en   (pop_ok),
      .rd_addr (odd_addr),
      .rd_data (odd_q)
   );

   always_comb begin
      hi_word = odd_ff ? odd_q : even_q;
      lo_word = odd_ff ? even_q : odd_q;
      rsp_pop_data = '0;
      if (pop_ff) begin
         rsp_pop_data = two_ff ? {hi_word, lo_word} : {{(DATA_W - WORD_W){1'b0}}, hi_word};
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_error_code = err_ff;
   assign rsp_depth      = DEPTH_W'(sp_ff);
   assign rsp_is_empty   = (sp_ff == '0);

   // checks
   `OSTACK_ASSERT_NEXT(a_one_cycle_rsp, accept, rsp_strobe, "word accepted without response")
   `OSTACK_ASSERT_NEXT(a_no_stray_rsp, !accept, !rsp_strobe, "response without a word")
   `OSTACK_ASSERT_NOW(a_sp_bound, 1'b1, sp_ff <= SP_W'(STACK_DEPTH), "stack pointer past capacity")
   `OSTACK_ASSERT_NOW(a_err_keeps_sp, rsp_strobe && (err_ff != ERR_OK), $stable(sp_ff), "error moved the stack pointer")
   `OSTACK_ASSERT_NOW(a_err_no_data, rsp_strobe && (err_ff != ERR_OK), rsp_pop_data == '0, "error response carries data")

endmodule

`default_nettype wire

### hdl/ostack_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ostack_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### tb/sv/operand_stack_one_two_slot_unit_tb.sv
// self-checking testbench for the operand stack unit: directed table, then random phases
`timescale 1ns / 1ps
`default_nettype none

module operand_stack_one_two_slot_unit_tb
   import ostack_pkg::*;
();

   localparam int STACK_SLOTS  = 256;
   localparam int RANDOM_WORDS = 950;
   localparam int IDLE_LIMIT   = 500;

   typedef struct packed {
      logic [DATA_W-1:0]  pop_data;
      err_type            error_code;
      logic [DEPTH_W-1:0] depth;
      logic               is_empty;
   } stack_rsp_type;

   typedef struct {
      op_type            op;
      logic [DATA_W-1:0] data;
      bit                typed;
      stack_rsp_type     rsp;
   } dir_row_type;

   typedef enum int {
      MODE_MIXED,
      MODE_FILL,
      MODE_DRAIN
   } gen_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_op = '0;
   logic [DATA_W-1:0]  req_push_data = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [DATA_W-1:0]  rsp_pop_data;
   logic [1:0]         rsp_error_code;
   logic [DEPTH_W-1:0] rsp_depth;
   logic               rsp_is_empty;

   logic [WORD_W-1:0]  slot_model [STACK_SLOTS];
   int                 slot_count = 0;
   stack_rsp_type      pending_rsp [$];
   dir_row_type        dir_rows [$];
   int                 mismatch_count = 0;
   int                 burst_left = 0;
   int                 idle_cycles = 0;

   operand_stack_one_two_slot_unit #(
      .STACK_DEPTH(STACK_SLOTS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_push_data  (req_push_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_pop_data   (rsp_pop_data),
      .rsp_error_code (rsp_error_code),
      .rsp_depth      (rsp_depth),
      .rsp_is_empty   (rsp_is_empty)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic stack_rsp_type predict_rsp(op_type op, logic [DATA_W-1:0] data);
      stack_rsp_type r;
      r.pop_data   = '0;
      r.error_code = ERR_OK;
      case (op)
         OP_PUSH1: begin
            if (slot_count + 1 > STACK_SLOTS) begin
               r.error_code = ERR_OVERFLOW;
            end else begin
               slot_model[slot_count] = data[WORD_W-1:0];
               slot_count += 1;
            end
         end
         OP_PUSH2: begin
            if (slot_count + 2 > STACK_SLOTS) begin
               r.error_code = ERR_OVERFLOW;
            end else begin
               slot_model[slot_count]     = data[DATA_W-1:WORD_W];
               slot_model[slot_count + 1] = data[WORD_W-1:0];
               slot_count += 2;
            end
         end
         OP_POP1: begin
            if (slot_count < 1) begin
               r.error_code = ERR_UNDERFLOW;
            end else begin
               slot_count -= 1;
               r.pop_data = {{WORD_W{1'b0}}, slot_model[slot_count]};
            end
         end
         OP_POP2: begin
            if (slot_count < 2) begin
               r.error_code = ERR_UNDERFLOW;
            end else begin
               slot_count -= 2;
               r.pop_data = {slot_model[slot_count], slot_model[slot_count + 1]};
            end
         end
      endcase
      r.depth    = DEPTH_W'(slot_count);
      r.is_empty = (slot_count == 0);
      return r;
   endfunction

   task automatic add_row(input op_type op, input logic [DATA_W-1:0] data, input bit typed,
                          input logic [DATA_W-1:0] pop, input err_type err,
                          input logic [DEPTH_W-1:0] depth, input logic empty);
      dir_row_type row;
      row.op  = op;
      row.data = data;
      row.typed = typed;
      row.rsp = '{pop_data: pop, error_code: err, depth: depth, is_empty: empty};
      dir_rows.push_back(row);
   endtask

   // called at a rising edge; returns at the edge that accepts the word
   task automatic send_word(input op_type op, input logic [DATA_W-1:0] data,
                            output stack_rsp_type predicted);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         req_op <= 2'($urandom);
         req_push_data <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 48);
      end
      burst_left -= 1;
      start <= 1'b1;
      req_op <= op;
      req_push_data <= data;
      do @(posedge clock); while (!(start && !busy));
      predicted = predict_rsp(op, data);
   endtask

   always @(posedge clock) begin
      stack_rsp_type got;
      stack_rsp_type want;
      if (!reset && rsp_strobe) begin
         got = '{pop_data: rsp_pop_data, error_code: err_type'(rsp_error_code),
                 depth: rsp_depth, is_empty: rsp_is_empty};
         if (pending_rsp.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected rsp word: pop=%h err=%0d depth=%0d empty=%0d",
                        got.pop_data, got.error_code, got.depth, got.is_empty);
            mismatch_count += 1;
         end else begin
            want = pending_rsp.pop_front();
            if (got.pop_data !== want.pop_data || got.error_code !== want.error_code ||
                got.depth !== want.depth || got.is_empty !== want.is_empty) begin
               if (mismatch_count < 10)
                  $display("rsp mismatch: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                           want.pop_data, want.error_code, want.depth, want.is_empty,
                           got.pop_data, got.error_code, got.depth, got.is_empty);
               mismatch_count += 1;
            end
         end
      end
   end

   // watchdog on cycles with no traffic on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      stack_rsp_type     predicted;
      op_type            op;
      logic [DATA_W-1:0] data;
      int                sel;
      gen_mode_type      mode;
      int                mode_left;
      int                edge_left;

      // underflow from empty, extremes, zero-extension, word order of two-slot values
      add_row(OP_POP1,  64'h0, 1'b1, 64'h0, ERR_UNDERFLOW, 9'd0, 1'b1);
      add_row(OP_POP2,  64'h0, 1'b1, 64'h0, ERR_UNDERFLOW, 9'd0, 1'b1);
      add_row(OP_PUSH1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, ERR_OK, 9'd1, 1'b0);
      add_row(OP_POP1,  64'h0, 1'b1, 64'h0000_0000_FFFF_FFFF, ERR_OK, 9'd0, 1'b1);
      add_row(OP_PUSH1, 64'h0, 1'b1, 64'h0, ERR_OK, 9'd1, 1'b0);
      add_row(OP_POP2,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, ERR_UNDERFLOW, 9'd1, 1'b0);
      add_row(OP_POP1,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, ERR_OK, 9'd0, 1'b1);
      add_row(OP_PUSH2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, ERR_OK, 9'd2, 1'b0);
      add_row(OP_POP2,  64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ERR_OK, 9'd0, 1'b1);
      add_row(OP_PUSH2, 64'h0, 1'b1, 64'h0, ERR_OK, 9'd2, 1'b0);
      add_row(OP_POP2,  64'h0, 1'b1, 64'h0, ERR_OK, 9'd0, 1'b1);
      add_row(OP_PUSH2, 64'h0123_4567_89AB_CDEF, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_POP1,  64'h0, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_POP1,  64'h0, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_PUSH1, 64'hDEAD_BEEF_0000_0001, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_PUSH1, 64'h0000_0000_8000_0000, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_POP2,  64'h0, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_PUSH2, 64'h8000_0000_0000_0001, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_PUSH1, 64'h5555_5555_AAAA_AAAA, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_POP2,  64'h0, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_POP1,  64'h0, 1'b0, '0, ERR_OK, '0, 1'b0);
      add_row(OP_POP1,  64'h0, 1'b1, 64'h0, ERR_UNDERFLOW, 9'd0, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].op, dir_rows[i].data, predicted);
         pending_rsp.push_back(dir_rows[i].typed ? dir_rows[i].rsp : predicted);
      end

      // mixed traffic, then fill to overflow and drain to underflow, repeated
      mode = MODE_MIXED;
      mode_left = 30;
      edge_left = 8;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         sel = $urandom_range(0, 99);
         case (mode)
            MODE_FILL:  op = (sel < 85) ? op_type'($urandom_range(OP_PUSH1, OP_PUSH2))
                                        : op_type'($urandom_range(OP_PUSH1, OP_POP2));
            MODE_DRAIN: op = (sel < 85) ? op_type'($urandom_range(OP_POP1, OP_POP2))
                                        : op_type'($urandom_range(OP_PUSH1, OP_POP2));
            default:    op = op_type'($urandom_range(OP_PUSH1, OP_POP2));
         endcase
         sel = $urandom_range(0, 15);
         data = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
         send_word(op, data, predicted);
         pending_rsp.push_back(predicted);
         case (mode)
            MODE_FILL: begin
               if (slot_count >= STACK_SLOTS - 1) edge_left -= 1;
               if (edge_left == 0) begin
                  mode = MODE_DRAIN;
                  edge_left = 8;
               end
            end
            MODE_DRAIN: begin
               if (slot_count <= 1) edge_left -= 1;
               if (edge_left == 0) begin
                  mode = MODE_MIXED;
                  mode_left = $urandom_range(20, 60);
                  edge_left = 8;
               end
            end
            default: begin
               mode_left -= 1;
               if (mode_left == 0) mode = MODE_FILL;
            end
         endcase
      end
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
